// File: rtl/array_list_engine_assert.svh
// Assertion macros used by the list engine checker.
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ale_pkg.sv
// Types and constants of the list engine.
package ale_pkg;

    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 7;
    localparam int FOUND_W    = 6;
    localparam int TOTAL_W    = 7;

    // Item opcodes.
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_FIND       = 3'd6
    } opcode_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CK_HOLD   = 3'd0,
        CK_INSERT = 3'd1,
        CK_ERASE  = 3'd2,
        CK_LOAD   = 3'd3,
        CK_SCAN   = 3'd4
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t           kind;
        logic [VALUE_W-1:0]   value;
    } cell_cmd_t;

    // Input item.
    typedef struct packed {
        opcode_t                   opcode;
        logic [POSITION_W-1:0]     position;
        logic signed [VALUE_W-1:0] value;
    } ale_in_t;

    // Result item.
    typedef struct packed {
        status_t              status;
        logic [FOUND_W-1:0]   found_index;
        logic [TOTAL_W-1:0]   element_total;
    } ale_out_t;

endpackage

// File: rtl/array_list_engine.sv
// Top level of the list engine: controller and the row of element cells.
// Results: every item but a find, and a find on an empty list, give their result in the
// cycle after acceptance. A find on a non-empty list first loads the match flags, then walks
// them toward cell zero up to the lowest matching index, or count-1 when nothing matches; busy is high meanwhile.
// Throughput: one item per cycle except during a find, whose match flags move down the
// cell chain one cell per cycle. Reset clears the count and control; stored values are kept.
module array_list_engine
    import ale_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ale_in_t  item,
    output logic     busy,
    output logic     done,
    output ale_out_t result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [IW-1:0]   scan_cnt_reg;
    logic [IW-1:0]   scan_cnt_next;
    logic            done_reg;
    logic            done_next;
    ale_out_t        res_reg;
    ale_out_t        res_next;

    logic            accept;
    logic            full;
    logic            empty;
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   cnt_ext;
    logic [PW-1:0]   cell_pos;
    cell_cmd_t       cell_cmd;
    status_t         op_status;
    logic            head_match;
    logic            scan_last;

    logic [VALUE_W-1:0] cell_data  [CAPACITY];
    logic               cell_match [CAPACITY];

    assign accept  = start && (state_reg == S_IDLE);
    assign full    = (count_reg == CAP_CNT);
    assign empty   = (count_reg == '0);
    assign pos_ext = PW'(item.position);
    assign cnt_ext = PW'(count_reg);
    assign head_match = cell_match[0];
    assign scan_last  = (CW'(scan_cnt_reg) == count_reg - CW'(1));

    // Decode the accepted item into a cell command, a status and the new count; during a scan, command a shift.
    always_comb
    begin
        cell_cmd.kind  = CK_HOLD;
        cell_cmd.value = item.value;
        cell_pos       = '0;
        op_status      = ST_OK;
        count_next     = count_reg;
        if (state_reg == S_SCAN)
        begin
            cell_cmd.kind = CK_SCAN;
        end
        else if (accept)
        begin
            unique case (item.opcode)
                OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT:
                begin
                    if (item.opcode == OP_PUSH_BACK)
                    begin
                        cell_pos = cnt_ext;
                    end
                    else if (item.opcode == OP_INSERT)
                    begin
                        cell_pos = pos_ext;
                    end
                    if (cell_pos > cnt_ext)
                    begin
                        op_status = ST_BADPOS;
                    end
                    else if (full)
                    begin
                        op_status = ST_FULL;
                    end
                    else
                    begin
                        cell_cmd.kind = CK_INSERT;
                        count_next    = count_reg + CW'(1);
                    end
                end
                OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        op_status = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_POP_FRONT, OP_ERASE:
                begin
                    if (item.opcode == OP_ERASE)
                    begin
                        cell_pos = pos_ext;
                    end
                    if (empty)
                    begin
                        op_status = ST_EMPTY;
                    end
                    else if (cell_pos >= cnt_ext)
                    begin
                        op_status = ST_BADPOS;
                    end
                    else
                    begin
                        cell_cmd.kind = CK_ERASE;
                        count_next    = count_reg - CW'(1);
                    end
                end
                OP_FIND:
                begin
                    if (empty)
                    begin
                        op_status = ST_NOTFOUND;
                    end
                    else
                    begin
                        cell_cmd.kind = CK_LOAD;
                    end
                end
                default:
                begin
                    op_status = ST_OK;
                end
            endcase
        end
    end

    // Sequencer: items other than a find on a non-empty list finish at once, a find walks the match flags.
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cell_cmd.kind == CK_LOAD)
                    begin
                        state_next    = S_SCAN;
                        scan_cnt_next = '0;
                    end
                    else
                    begin
                        done_next              = 1'b1;
                        res_next.status        = op_status;
                        res_next.found_index   = '0;
                        res_next.element_total = TOTAL_W'(count_next);
                    end
                end
            end
            S_SCAN:
            begin
                if (head_match || scan_last)
                begin
                    state_next             = S_IDLE;
                    done_next              = 1'b1;
                    res_next.status        = head_match ? ST_OK : ST_NOTFOUND;
                    res_next.found_index   = head_match ? FOUND_W'(scan_cnt_reg) : '0;
                    res_next.element_total = TOTAL_W'(count_reg);
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + IW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // The chain of cells; the ends see themselves or nothing beyond the list.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_W-1:0] left_d;
        logic [VALUE_W-1:0] right_d;
        logic               right_m;

        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_inner_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
            assign right_m = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_d = cell_data[i+1];
            assign right_m = cell_match[i+1];
        end

        ale_cell #(
            .IDX (i),
            .PW  (PW),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd),
            .pos         (cell_pos),
            .count       (count_reg),
            .left_data   (left_d),
            .right_data  (right_d),
            .right_match (right_m),
            .data        (cell_data[i]),
            .match       (cell_match[i])
        );
    end

    assign busy   = (state_reg == S_SCAN);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: rtl/ale_cell.sv
// One list cell: holds one element and a match flag, trades both with its neighbors.
module ale_cell
    import ale_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 7,
    parameter int CW  = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_cmd_t          cmd,
    input  logic [PW-1:0]      pos,
    input  logic [CW-1:0]      count,
    input  logic [VALUE_W-1:0] left_data,
    input  logic [VALUE_W-1:0] right_data,
    input  logic               right_match,
    output logic [VALUE_W-1:0] data,
    output logic               match
);

    localparam logic [PW-1:0] MY_POS = PW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               match_reg;
    logic               match_next;

    // Element update: insertion opens a gap at pos, erasure closes it.
    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.kind)
            CK_INSERT:
            begin
                if (MY_POS == pos)
                begin
                    data_next = cmd.value;
                end
                else if (MY_POS > pos)
                begin
                    data_next = left_data;
                end
            end
            CK_ERASE:
            begin
                if (MY_POS >= pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Match flag: loaded by compare, then handed down toward cell zero.
    always_comb
    begin
        match_next = match_reg;
        unique case (cmd.kind)
            CK_LOAD:    match_next = (data_reg == cmd.value) && (MY_CNT < count);
            CK_SCAN:    match_next = right_match;
            default:    match_next = match_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// File: rtl/ale_checker.sv
// Port-level checker for the list engine and its bind to the top level.
`include "array_list_engine_assert.svh"

module ale_checker
    import ale_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input ale_in_t  item,
    input logic     busy,
    input logic     done,
    input ale_out_t result
);

    // Anything but a find finishes in the next cycle without going busy.
    `ALE_ASSERT_NEXT(a_quick_item, start && !busy && (item.opcode != OP_FIND), done && !busy, "non-find item did not finish in one cycle")

    // An accepted find either finishes at once or starts the scan.
    `ALE_ASSERT_NEXT(a_find_starts, start && !busy && (item.opcode == OP_FIND), busy || done, "find item neither finished nor started a scan")

    // The end of a scan always delivers its result.
    `ALE_ASSERT_NOW(a_scan_ends, $fell(busy), done, "scan ended without a result")

    // A failed item reports index zero.
    `ALE_ASSERT_NOW(a_index_zero, done && (result.status != ST_OK), result.found_index == '0, "failed item reported a nonzero index")

endmodule

bind array_list_engine ale_checker u_ale_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the list engine: directed and random list operations.
module tb;
    import ale_pkg::*;

    localparam int CAPACITY = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASE_LEN = 125;

    // Holds a shadow copy of the list and the results it predicts.
    class list_scoreboard;
        logic [VALUE_W-1:0] store [CAPACITY];
        int count;
        ale_out_t awaited [$];
        int mismatches;

        function new();
            count = 0;
            mismatches = 0;
        endfunction

        // Insert at a position, shifting the tail up.
        function status_t place(int pos, logic [VALUE_W-1:0] v);
            if (pos > count)
                return ST_BADPOS;
            if (count >= CAPACITY)
                return ST_FULL;
            for (int i = count; i > pos; i--)
                store[i] = store[i - 1];
            store[pos] = v;
            count++;
            return ST_OK;
        endfunction

        // Remove at a position, shifting the tail down.
        function status_t remove(int pos);
            if (count == 0)
                return ST_EMPTY;
            if (pos >= count)
                return ST_BADPOS;
            for (int i = pos; i + 1 < count; i++)
                store[i] = store[i + 1];
            count--;
            return ST_OK;
        endfunction

        // Applies one accepted item to the shadow list and queues its result.
        function void note(ale_in_t it);
            ale_out_t r;
            r.status = ST_OK;
            r.found_index = '0;
            case (it.opcode)
                OP_PUSH_BACK:  r.status = place(count, it.value);
                OP_POP_BACK:
                begin
                    if (count == 0)
                        r.status = ST_EMPTY;
                    else
                        count--;
                end
                OP_PUSH_FRONT: r.status = place(0, it.value);
                OP_POP_FRONT:  r.status = remove(0);
                OP_INSERT:     r.status = place(int'(it.position), it.value);
                OP_ERASE:      r.status = remove(int'(it.position));
                OP_FIND:
                begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < count; i++)
                    begin
                        if (store[i] == it.value)
                        begin
                            r.status = ST_OK;
                            r.found_index = FOUND_W'(i);
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.element_total = TOTAL_W'(count);
            awaited.push_back(r);
        endfunction

        task report(string field, int got, int want);
            $display("mismatch in %s: got %0d, expected %0d at %0t", field, got, want, $time);
            mismatches++;
        endtask

        // Compares one result item with the oldest prediction.
        task check(ale_out_t got);
            ale_out_t want;
            if (awaited.size() == 0)
            begin
                report("status of unexpected result", int'(got.status), -1);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report("status", int'(got.status), int'(want.status));
            if (got.found_index !== want.found_index)
                report("found_index", int'(got.found_index), int'(want.found_index));
            if (got.element_total !== want.element_total)
                report("element_total", int'(got.element_total), int'(want.element_total));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    ale_in_t  item;
    logic     busy;
    logic     done;
    ale_out_t result;

    list_scoreboard sb;
    int fill_bias;
    int idle_pct;
    int stall_cycles;

    array_list_engine uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results are checked as they appear; the receiver never holds them off.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(result);
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL array_list_engine");
            $finish;
        end
    end

    // Offers one item and waits until the block takes it.
    task send(ale_in_t it);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note(it);
    endtask

    task send_op(opcode_t op, int pos, logic [VALUE_W-1:0] v);
        ale_in_t it;
        it.opcode = op;
        it.position = POSITION_W'(pos);
        it.value = v;
        send(it);
    endtask

    // Holds the sender off until every predicted result has arrived.
    task pause_until_settled();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Many small values, some extremes, the rest random, so that finds hit and duplicates occur.
    function logic [VALUE_W-1:0] pick_value();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            v = int'($urandom_range(0, 6)) - 3;
            return v;
        end
        if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // Builds one random item; fill_bias steers the list toward full or empty.
    function ale_in_t make_item();
        ale_in_t it;
        int r;
        int cnt;
        cnt = sb.count;
        it.value = pick_value();
        it.position = POSITION_W'($urandom_range(0, CAPACITY));
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            it.opcode = OP_FIND;
            if (cnt > 0 && $urandom_range(0, 99) < 60)
                it.value = sb.store[$urandom_range(0, cnt - 1)];
        end
        else if ($urandom_range(0, 99) < fill_bias)
        begin
            case ($urandom_range(0, 2))
                0: it.opcode = OP_PUSH_BACK;
                1: it.opcode = OP_PUSH_FRONT;
                default:
                begin
                    it.opcode = OP_INSERT;
                    if ($urandom_range(0, 99) < 80)
                        it.position = POSITION_W'($urandom_range(0, cnt));
                end
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: it.opcode = OP_POP_BACK;
                1: it.opcode = OP_POP_FRONT;
                default:
                begin
                    it.opcode = OP_ERASE;
                    if (cnt > 0 && $urandom_range(0, 99) < 80)
                        it.position = POSITION_W'($urandom_range(0, cnt - 1));
                end
            endcase
        end
        return it;
    endfunction

    initial
    begin
        int gap;
        sb = new();
        fill_bias = 75;
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, extremes, bad positions, duplicates and lookups.
        send_op(OP_POP_BACK, 0, 32'h0);
        send_op(OP_POP_FRONT, 0, 32'h0);
        send_op(OP_ERASE, 64, 32'h0);
        send_op(OP_FIND, 0, 32'h0);
        send_op(OP_INSERT, 1, 32'h1);
        send_op(OP_INSERT, 0, 32'h8000_0000);
        send_op(OP_PUSH_BACK, 0, 32'h7fff_ffff);
        send_op(OP_PUSH_FRONT, 0, 32'hffff_ffff);
        send_op(OP_PUSH_BACK, 0, 32'h0);
        send_op(OP_INSERT, 4, 32'h0);
        send_op(OP_INSERT, 2, 32'h5555_5555);
        send_op(OP_FIND, 0, 32'h0);
        send_op(OP_FIND, 0, 32'h7fff_ffff);
        send_op(OP_FIND, 0, 32'h1234_5678);
        send_op(OP_ERASE, 6, 32'h0);
        send_op(OP_ERASE, 64, 32'h0);
        send_op(OP_INSERT, 64, 32'haaaa_aaaa);
        send_op(OP_ERASE, 2, 32'h0);
        send_op(OP_POP_FRONT, 0, 32'h0);
        send_op(OP_POP_BACK, 0, 32'h0);
        send_op(OP_FIND, 0, 32'h8000_0000);
        send_op(OP_ERASE, 0, 32'h0);
        pause_until_settled();

        // Random part: fill and drain swings, with three sender idling phases.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / PHASE_LEN) % 3)
                0: idle_pct = 0;
                1: idle_pct = 48;
                default: idle_pct = 7;
            endcase
            if (sb.count == CAPACITY && $urandom_range(0, 3) == 0)
                fill_bias = 25;
            else if (sb.count == 0 && $urandom_range(0, 3) == 0)
                fill_bias = 75;
            else if ($urandom_range(0, 59) == 0)
                fill_bias = 50;
            send(make_item());
            if (n % 400 == 399)
                pause_until_settled();
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                gap = $urandom_range(1, 3);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("PASS array_list_engine");
        else
            $display("FAIL array_list_engine");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ale_pkg.sv
rtl/ale_cell.sv
rtl/array_list_engine.sv
rtl/ale_checker.sv
dv/tb.sv
